// ===== design/bfca_pkg.sv =====
// ---------------------------------------------------------------------------
// bfca_pkg
// Shared constants, word types and status codes of the best-fit allocator.
// ---------------------------------------------------------------------------
package bfca_pkg;

    localparam int CELLS     = 2048;
    localparam int ID_BITS   = 10;
    localparam int ADDR_BITS = $clog2(CELLS);
    // wide enough to hold CELLS itself (run lengths, scan terminator)
    localparam int CNT_BITS  = ADDR_BITS + 1;

    localparam int TYPE_W  = 1;
    localparam int PID_W   = 10;
    localparam int BSIZE_W = 12;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 11;
    localparam int FSIZE_W = 12;

    localparam logic [TYPE_W-1:0] REQ_ALLOC = 1'b0;
    localparam logic [TYPE_W-1:0] REQ_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_ALLOCATED = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FIT    = 2'd1;
    localparam logic [STAT_W-1:0] ST_FREED     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [TYPE_W-1:0]  req_type;
        logic [PID_W-1:0]   proc_id;
        logic [BSIZE_W-1:0] block_size;
    } bfca_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [POS_W-1:0]   position;
        logic [FSIZE_W-1:0] freed_size;
    } bfca_rsp_t;

endpackage

// ===== design/bfca_ram.sv =====
// ---------------------------------------------------------------------------
// bfca_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module bfca_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 10
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/bfca_ctrl.sv =====
// ---------------------------------------------------------------------------
// bfca_ctrl
// Sequencer: clearing pass, map scan (hole search or id clear), block fill.
// ---------------------------------------------------------------------------
module bfca_ctrl
    import bfca_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  bfca_req_t req,
    output logic      res_valid,
    input  logic      res_ready,
    output bfca_rsp_t res
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_FILL  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    localparam logic [CNT_BITS-1:0] TERM = CNT_BITS'(CELLS);

    state_t                state_reg, state_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic [CNT_BITS-1:0]   chk_addr_reg, chk_addr_next;
    logic [TYPE_W-1:0]     kind_reg, kind_next;
    logic [ID_BITS-1:0]    id_reg, id_next;
    logic [CNT_BITS-1:0]   size_reg, size_next;
    logic [ADDR_BITS-1:0]  run_start_reg, run_start_next;
    logic [CNT_BITS-1:0]   run_len_reg, run_len_next;
    logic                  found_reg, found_next;
    logic [ADDR_BITS-1:0]  best_start_reg, best_start_next;
    logic [CNT_BITS-1:0]   best_len_reg, best_len_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    bfca_rsp_t             res_reg, res_next;

    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [ID_BITS-1:0]    wr_data;
    logic                  rd_en;
    logic [ID_BITS-1:0]    rd_data;

    logic                  is_term;
    logic                  is_free;
    logic                  hole_fits;
    logic [ID_BITS-1:0]    req_id;

    bfca_ram #(
        .DEPTH (CELLS),
        .WIDTH (ID_BITS)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg[ADDR_BITS-1:0]),
        .rd_data (rd_data)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;
    assign req_id    = req.proc_id[ID_BITS-1:0];

    assign is_term   = (chk_addr_reg == TERM);
    assign is_free   = !is_term && (rd_data == '0);
    assign hole_fits = (run_len_reg >= size_reg) &&
                       (!found_reg || (run_len_reg < best_len_reg));

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        chk_vld_next    = 1'b0;
        chk_addr_next   = chk_addr_reg;
        kind_next       = kind_reg;
        id_next         = id_reg;
        size_next       = size_reg;
        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        found_next      = found_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        count_next      = count_reg;
        res_next        = res_reg;
        wr_en           = 1'b0;
        wr_addr         = cnt_reg[ADDR_BITS-1:0];
        wr_data         = '0;
        rd_en           = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next      = req.req_type;
                    id_next        = req_id;
                    size_next      = CNT_BITS'(req.block_size);
                    cnt_next       = '0;
                    run_len_next   = '0;
                    found_next     = 1'b0;
                    count_next     = '0;
                    best_start_next = '0;
                    best_len_next  = '0;
                    state_next     = S_SCAN;
                    if (req.req_type == REQ_ALLOC)
                    begin
                        if (req_id == '0 || req.block_size == '0 ||
                            32'(req.block_size) > CELLS)
                        begin
                            res_next   = '{ST_NO_FIT, '0, '0};
                            state_next = S_DONE;
                        end
                    end
                    else if (req_id == '0)
                    begin
                        res_next   = '{ST_NOT_FOUND, '0, '0};
                        state_next = S_DONE;
                    end
                end
            end

            S_SCAN:
            begin
                // issue side: cells 0..CELLS-1, then one terminator slot
                if (cnt_reg <= TERM)
                begin
                    rd_en         = (cnt_reg != TERM);
                    chk_vld_next  = 1'b1;
                    chk_addr_next = cnt_reg;
                    cnt_next      = cnt_reg + 1'b1;
                end

                // check side: data of chk_addr_reg is on rd_data
                if (chk_vld_reg)
                begin
                    if (kind_reg == REQ_ALLOC)
                    begin
                        if (is_free)
                        begin
                            if (run_len_reg == '0)
                            begin
                                run_start_next = chk_addr_reg[ADDR_BITS-1:0];
                            end
                            run_len_next = run_len_reg + 1'b1;
                        end
                        else
                        begin
                            if (hole_fits)
                            begin
                                found_next      = 1'b1;
                                best_start_next = run_start_reg;
                                best_len_next   = run_len_reg;
                            end
                            run_len_next = '0;
                        end
                        if (is_term)
                        begin
                            cnt_next     = '0;
                            chk_vld_next = 1'b0;
                            if (found_reg || hole_fits)
                            begin
                                state_next = S_FILL;
                            end
                            else
                            begin
                                res_next   = '{ST_NO_FIT, '0, '0};
                                state_next = S_DONE;
                            end
                        end
                    end
                    else
                    begin
                        // free: clear the matching cell when its read data is checked
                        if (!is_term && rd_data == id_reg)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = chk_addr_reg[ADDR_BITS-1:0];
                            if (!found_reg)
                            begin
                                found_next      = 1'b1;
                                best_start_next = chk_addr_reg[ADDR_BITS-1:0];
                            end
                            count_next = count_reg + 1'b1;
                        end
                        if (is_term)
                        begin
                            chk_vld_next = 1'b0;
                            if (found_reg)
                            begin
                                res_next = '{ST_FREED, POS_W'(best_start_reg),
                                             FSIZE_W'(count_reg)};
                            end
                            else
                            begin
                                res_next = '{ST_NOT_FOUND, '0, '0};
                            end
                            state_next = S_DONE;
                        end
                    end
                end
            end

            S_FILL:
            begin
                wr_en    = 1'b1;
                wr_addr  = best_start_reg + cnt_reg[ADDR_BITS-1:0];
                wr_data  = id_reg;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == size_reg - 1'b1)
                begin
                    res_next   = '{ST_ALLOCATED, POS_W'(best_start_reg), '0};
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            chk_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            chk_vld_reg <= chk_vld_next;
            found_reg   <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_addr_reg   <= chk_addr_next;
        kind_reg       <= kind_next;
        id_reg         <= id_next;
        size_reg       <= size_next;
        run_start_reg  <= run_start_next;
        run_len_reg    <= run_len_next;
        best_start_reg <= best_start_next;
        best_len_reg   <= best_len_next;
        count_reg      <= count_next;
        res_reg        <= res_next;
    end

    // hole search never touches the map
    a_alloc_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && kind_reg == REQ_ALLOC) |-> !wr_en)
        else $error("map written during hole search");

    // a free only clears a cell that was just read with the matching id
    a_free_write_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && wr_en) |->
            (chk_vld_reg && rd_data == id_reg && wr_data == '0))
        else $error("free cleared a cell of another owner");

    // fill stays inside the requested size
    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> (cnt_reg < size_reg && found_reg))
        else $error("fill ran past block size");

    // a word is only presented after a scan, fill or early reject
    a_done_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && $past(state_reg) != S_DONE) |->
            ($past(state_reg) == S_IDLE || $past(state_reg) == S_SCAN ||
             $past(state_reg) == S_FILL))
        else $error("result raised from wrong state");

endmodule

// ===== design/best_fit_cell_allocator.sv =====
// Allocate: a scan of the whole map, a fill of block_size cells, a result state and
//   the output register; free: the map scan, the result state and the output register.
// Rejected words (zero id, zero or oversize block) skip the scan and go from idle to the result state.
// One request at a time, set by the single read and write port of the owner map;
//   the next request is taken the cycle after its result moves to the output register.
// After rst_n, a clearing pass over all CELLS cells zeroes the map; req_ready low.
// ---------------------------------------------------------------------------
// best_fit_cell_allocator
// Best-fit contiguous allocator over an owner map of CELLS cells.
// ---------------------------------------------------------------------------
module best_fit_cell_allocator
    import bfca_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  bfca_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output bfca_rsp_t rsp
);

    logic      res_valid;
    logic      res_ready;
    bfca_rsp_t res;
    logic      out_valid_reg, out_valid_next;
    bfca_rsp_t out_reg;

    bfca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output word register
    assign res_ready = !out_valid_reg || rsp_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Drives allocate and free words into the best-fit allocator through its
// request/response handshakes and checks every response against a local
// model of the owner map: best-fit placement, lowest-address ties, frees of
// duplicate ids, zero and oversize requests, and a block ending at the last
// cell. Both sides idle at random, the response side holds off once long
// enough to back up the request side, and the request side drains once.
// ---------------------------------------------------------------------------
module tb_top
    import bfca_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // bound on one request: a full map scan plus a fill of up to CELLS cells, with margin
    localparam int WORD_LATENCY  = 2 * CELLS + 200;
    localparam int HOLD_CYCLES   = 12000;
    localparam int STALL_LIMIT   = 60000;
    localparam int RANDOM_WORDS  = 120;

    class alloc_scoreboard;
        logic [PID_W-1:0] owner [CELLS];
        bfca_rsp_t        pending_q [$];
        int               mismatches;
        int               n_placed;
        int               n_no_fit;
        int               n_freed;
        int               n_not_found;

        function new();
            foreach (owner[i]) owner[i] = '0;
            mismatches  = 0;
            n_placed    = 0;
            n_no_fit    = 0;
            n_freed     = 0;
            n_not_found = 0;
        endfunction

        // apply one accepted request to the local map and queue its response
        function void note_request(bfca_req_t w);
            bfca_rsp_t want;
            int        id;
            int        size;
            int        run_start;
            int        run_len;
            int        best_start;
            int        best_len;
            int        first_cell;
            int        count;
            bit        found;
            want = '0;
            id   = int'(w.proc_id);
            size = int'(w.block_size);
            if (w.req_type == REQ_ALLOC)
            begin
                want.status = ST_NO_FIT;
                if (id != 0 && size != 0 && size <= CELLS)
                begin
                    found      = 1'b0;
                    run_start  = 0;
                    run_len    = 0;
                    best_start = 0;
                    best_len   = 0;
                    // one step past the end closes a hole that reaches the last cell
                    for (int i = 0; i <= CELLS; i++)
                    begin
                        if (i < CELLS && owner[i] == '0)
                        begin
                            if (run_len == 0)
                                run_start = i;
                            run_len++;
                        end
                        else
                        begin
                            if (run_len >= size && (!found || run_len < best_len))
                            begin
                                found      = 1'b1;
                                best_start = run_start;
                                best_len   = run_len;
                            end
                            run_len = 0;
                        end
                    end
                    if (found)
                    begin
                        for (int i = 0; i < size; i++)
                            owner[best_start + i] = PID_W'(id);
                        want.status   = ST_ALLOCATED;
                        want.position = POS_W'(best_start);
                    end
                end
            end
            else
            begin
                want.status = ST_NOT_FOUND;
                count       = 0;
                first_cell  = 0;
                if (id != 0)
                begin
                    for (int i = 0; i < CELLS; i++)
                    begin
                        if (owner[i] == PID_W'(id))
                        begin
                            if (count == 0)
                                first_cell = i;
                            owner[i] = '0;
                            count++;
                        end
                    end
                end
                if (count > 0)
                begin
                    want.status     = ST_FREED;
                    want.position   = POS_W'(first_cell);
                    want.freed_size = FSIZE_W'(count);
                end
            end
            pending_q.push_back(want);
        endfunction

        function void check_result(bfca_rsp_t got);
            bfca_rsp_t want;
            case (got.status)
                ST_ALLOCATED: n_placed++;
                ST_NO_FIT:    n_no_fit++;
                ST_FREED:     n_freed++;
                default:      n_not_found++;
            endcase
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: word with nothing expected: status %0d pos %0d size %0d",
                             got.status, got.position, got.freed_size);
                return;
            end
            want = pending_q.pop_front();
            if (got.status !== want.status || got.position !== want.position ||
                got.freed_size !== want.freed_size)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status %0d pos %0d size %0d, got %0d %0d %0d",
                             want.status, want.position, want.freed_size,
                             got.status, got.position, got.freed_size);
            end
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    bfca_req_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    bfca_rsp_t rsp;

    alloc_scoreboard sb = new();

    bit no_idle;
    bit hold_off_req;
    int live_ids [$];

    best_fit_cell_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_request(req);
            if (rsp_valid === 1'b1 && rsp_ready)
                sb.check_result(rsp);
        end
    end

    function automatic bfca_req_t req_word(logic [TYPE_W-1:0] kind, int id, int size);
        bfca_req_t w;
        w.req_type   = kind;
        w.proc_id    = PID_W'(id);
        w.block_size = BSIZE_W'(size);
        return w;
    endfunction

    task automatic send_word(input bfca_req_t w);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(99) < 30)
        begin
            // long gaps land the next offer at any point of a scan
            if ($urandom_range(2) == 0)
                gap = $urandom_range(WORD_LATENCY, 1);
            else
                gap = $urandom_range(8, 1);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req       <= w;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // response side
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                rsp_ready <= no_idle || ($urandom_range(99) >= 30);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid === 1'b1 && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        bfca_req_t w;
        int        r;
        int        s;
        int        idx;
        int        id;
        int        size;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        no_idle      = 1'b0;
        hold_off_req = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words
        send_word(req_word(REQ_ALLOC, 1, CELLS));     // whole map, ends at last cell
        send_word(req_word(REQ_ALLOC, 2, 1));         // map full
        send_word(req_word(REQ_FREE, 1, 0));
        send_word(req_word(REQ_ALLOC, 3, 0));         // zero size
        send_word(req_word(REQ_ALLOC, 0, 5));         // zero id
        send_word(req_word(REQ_FREE, 0, 4095));       // zero id free
        send_word(req_word(REQ_ALLOC, 5, 4095));      // larger than the map
        send_word(req_word(REQ_ALLOC, 5, CELLS + 1));
        send_word(req_word(REQ_FREE, 999, 17));       // unknown id
        send_word(req_word(REQ_ALLOC, 1023, 100));
        send_word(req_word(REQ_ALLOC, 7, 200));
        send_word(req_word(REQ_ALLOC, 8, 50));
        send_word(req_word(REQ_FREE, 7, 0));          // opens a 200-cell hole
        send_word(req_word(REQ_ALLOC, 9, 150));       // best fit takes the small hole
        send_word(req_word(REQ_ALLOC, 1023, 30));     // duplicate id
        send_word(req_word(REQ_FREE, 1023, 0));       // clears both pieces
        send_word(req_word(REQ_ALLOC, 10, CELLS - 350)); // tail hole up to last cell
        send_word(req_word(REQ_FREE, 10, 0));
        send_word(req_word(REQ_ALLOC, 512, CELLS));
        send_word(req_word(REQ_FREE, 9, 0));
        send_word(req_word(REQ_FREE, 8, 0));
        send_word(req_word(REQ_FREE, 8, 0));          // already freed

        // random words
        for (int k = 0; k < RANDOM_WORDS; k++)
        begin
            if (k == 30)
                hold_off_req = 1'b1;
            if (k == 60)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                while (sb.outstanding() != 0) @(posedge clk);
            end
            no_idle = (k >= 75 && k < 105);

            r = $urandom_range(99);
            if (r < 55)
            begin
                id = $urandom_range(1023, 1);
                s  = $urandom_range(99);
                if (s < 75)
                    size = $urandom_range(64, 1);
                else if (s < 93)
                    size = $urandom_range(600, 65);
                else if (s < 98)
                    size = $urandom_range(CELLS, 601);
                else
                    size = $urandom_range(4095, 0);
                live_ids.push_back(id);
                w = req_word(REQ_ALLOC, id, size);
            end
            else if (r < 92)
            begin
                if (live_ids.size() > 0)
                begin
                    idx = $urandom_range(live_ids.size() - 1);
                    id  = live_ids[idx];
                    live_ids.delete(idx);
                end
                else
                begin
                    id = $urandom_range(1023, 1);
                end
                w = req_word(REQ_FREE, id, $urandom_range(4095));
            end
            else if (r < 96)
            begin
                w = req_word(REQ_ALLOC, 0, $urandom_range(4095));
            end
            else
            begin
                w = req_word(REQ_FREE, $urandom_range(1023), $urandom_range(4095));
            end
            send_word(w);
        end
        @(negedge clk);
        req_valid <= 1'b0;
        no_idle = 1'b0;

        while (sb.outstanding() != 0) @(posedge clk);
        repeat (WORD_LATENCY) @(posedge clk);

        $display("checked %0d words: %0d placed, %0d no fit, %0d freed, %0d id not found",
                 sb.n_placed + sb.n_no_fit + sb.n_freed + sb.n_not_found,
                 sb.n_placed, sb.n_no_fit, sb.n_freed, sb.n_not_found);
        $display("%0d mismatches, %0d responses still owed",
                 sb.mismatches, sb.outstanding());
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/bfca_pkg.sv
design/bfca_ram.sv
design/bfca_ctrl.sv
design/best_fit_cell_allocator.sv
tb/tb_top.sv
